### src/ttq_pkg.sv
// Shared constants and types for the timed tone queue.
package ttq_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned FreqW      = 16;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic {
    ReqAdd  = 1'b0,
    ReqTick = 1'b1
  } ttq_req_e;

  // Registered request word handed to the slot store.
  typedef struct packed {
    logic             vld;
    ttq_req_e         kind;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] duration_ms;
    logic [FreqW-1:0] freq;
    logic             clear_first;
  } ttq_req_t;

  // Status of the queue as seen by the current request.
  typedef struct packed {
    logic             empty;
    logic             expired;
    logic [FreqW-1:0] head_freq;
    logic             dropped;
  } ttq_status_t;

endpackage

### src/ttq_slots.sv
// Tone slot store: fill count, end times and frequencies, add and shift.
module ttq_slots (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ttq_pkg::ttq_req_t    req_i,
  output ttq_pkg::ttq_status_t status_o
);
  import ttq_pkg::*;

  logic [TimeW-1:0] end_q  [QueueDepth];
  logic [FreqW-1:0] freq_q [QueueDepth];
  logic [CntW-1:0]  count_q, count_d;

  logic [CntW-1:0]  base_cnt;
  logic             full;
  logic [IdxW-1:0]  wr_idx;
  logic [IdxW-1:0]  prev_idx;
  logic [TimeW-1:0] base_time;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] new_end;
  logic             do_add;
  logic             do_shift;

  // Slots hold a contiguous run from slot 0, so the first free slot is the count.
  assign base_cnt  = (req_i.clear_first) ? '0 : count_q;
  assign full      = (base_cnt == CntW'(QueueDepth));
  assign wr_idx    = base_cnt[IdxW-1:0];
  assign prev_idx  = IdxW'(base_cnt - CntW'(1));
  assign base_time = (base_cnt == '0) ? req_i.now_ms : end_q[prev_idx];
  assign sum       = {1'b0, base_time} + {1'b0, req_i.duration_ms};
  assign new_end   = sum[TimeW] ? TimeMax : sum[TimeW-1:0];

  assign status_o.empty     = (count_q == '0);
  assign status_o.expired   = (end_q[0] < req_i.now_ms);
  assign status_o.head_freq = freq_q[0];
  assign status_o.dropped   = req_i.vld && (req_i.kind == ReqAdd) && full;

  assign do_add   = req_i.vld && (req_i.kind == ReqAdd) && !full;
  assign do_shift = req_i.vld && (req_i.kind == ReqTick) && !status_o.empty
                    && status_o.expired;

  always_comb begin
    count_d = count_q;
    if (req_i.vld && (req_i.kind == ReqAdd)) begin
      count_d = full ? base_cnt : base_cnt + CntW'(1);
    end else if (do_shift) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_add) begin
      end_q[wr_idx]  <= new_end;
      freq_q[wr_idx] <= req_i.freq;
    end else if (do_shift) begin
      for (int i = 0; i + 1 < QueueDepth; i++) begin
        end_q[i]  <= end_q[i+1];
        freq_q[i] <= freq_q[i+1];
      end
    end
  end

endmodule

### src/timed_tone_queue.sv
// Top level of the timed tone queue: request register, drive state, result word.
// A request accepted into the request register has its result word on the
// outputs, with valid_o high for a single cycle, from the result register.
// Throughput: one request per cycle; busy_o stays low, the slot store
// settles each request while it sits in the request register.
// Reset: the queue empties and the drive turns off; no result is pending.
// The receiver cannot stall, so each result shows for exactly one cycle.
module timed_tone_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      req_type_i,
  input  logic [ttq_pkg::TimeW-1:0] now_ms_i,
  input  logic [ttq_pkg::TimeW-1:0] duration_ms_i,
  input  logic [ttq_pkg::FreqW-1:0] tone_freq_in_i,
  input  logic                      clear_first_i,
  output logic                      valid_o,
  output logic                      tone_on_o,
  output logic [ttq_pkg::FreqW-1:0] tone_freq_out_o,
  output logic                      dropped_o
);
  import ttq_pkg::*;

  ttq_req_t         req_q;
  ttq_status_t      status;
  logic             drive_on_q, drive_on_d;
  logic [FreqW-1:0] drive_freq_q, drive_freq_d;
  logic             valid_q;
  logic             tone_on_q;
  logic [FreqW-1:0] tone_freq_q;
  logic             dropped_q;

  // Every request settles while in the request register, so the block never pushes back.
  assign busy_o = 1'b0;

  // Request register: hold the accepted word while the slot store processes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q.vld <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        req_q.kind        <= ttq_req_e'(req_type_i);
        req_q.now_ms      <= now_ms_i;
        req_q.duration_ms <= duration_ms_i;
        req_q.freq        <= tone_freq_in_i;
        req_q.clear_first <= clear_first_i;
      end
    end
  end

  ttq_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .status_o (status)
  );

  // Drive update on a tick: off when empty, head frequency while the head
  // is live, and unchanged while an expired head shifts out.
  always_comb begin
    drive_on_d   = drive_on_q;
    drive_freq_d = drive_freq_q;
    if (req_q.vld && (req_q.kind == ReqTick)) begin
      if (status.empty) begin
        drive_on_d   = 1'b0;
        drive_freq_d = '0;
      end else if (!status.expired) begin
        drive_on_d   = 1'b1;
        drive_freq_d = status.head_freq;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_on_q   <= 1'b0;
      drive_freq_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      drive_on_q   <= drive_on_d;
      drive_freq_q <= drive_freq_d;
      valid_q      <= req_q.vld;
    end
  end

  // Result register: capture the drive as it stands after this request.
  always_ff @(posedge clk_i) begin
    if (req_q.vld) begin
      tone_on_q   <= drive_on_d;
      tone_freq_q <= drive_on_d ? drive_freq_d : '0;
      dropped_q   <= status.dropped;
    end
  end

  assign valid_o         = valid_q;
  assign tone_on_o       = tone_on_q;
  assign tone_freq_out_o = tone_freq_q;
  assign dropped_o       = dropped_q;

  // Every processed request yields exactly one result word next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.vld |=> valid_o)
    else $error("processed request gave no result word");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_q.vld |=> !valid_o)
    else $error("result word without a request");

  // A tick never reports a drop.
  a_tick_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_q.vld && (req_q.kind == ReqTick)) |=> !dropped_o)
    else $error("tick flagged as dropped");

  // With the drive off the reported frequency is zero.
  a_off_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !tone_on_o) |-> (tone_freq_out_o == '0))
    else $error("nonzero frequency while drive is off");

endmodule
